// ----- src/msmf_pkg.sv -----
// Shared types, constants and helpers of the multi-slot message FIFO.
package msmf_pkg;

	localparam int SLOTS         = 4;
	localparam int SLOT_W        = 2;
	localparam int MESSAGE_BYTES = 8;
	localparam int SLOT_BYTES    = 40;
	localparam int QUEUE_DEPTH   = 64;
	localparam int QPTR_W        = 6;
	localparam int STORE_AW      = SLOT_W + QPTR_W;
	localparam int STORE_DEPTH   = SLOTS * QUEUE_DEPTH;
	localparam int LEN_W         = 4;
	localparam int FILL_W        = 6;
	localparam int CAP_W         = 8;
	localparam int DATA_W        = 64;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 6;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOT = 1'd1;

	// opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_TOO_LONG  = 3'd1,
		STAT_NO_ROOM   = 3'd2,
		STAT_EMPTY     = 3'd3,
		STAT_SMALL_BUF = 3'd4
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} entry_t;

	// keep bytes below len, clear the rest
	function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < DATA_W / 8; i++) begin
			m[i*8 +: 8] = {8{LEN_W'(i) < len}};
		end
		return m;
	endfunction

endpackage

// ----- src/multi_slot_message_fifo.sv -----
// Top level: multi-slot message FIFO with per-slot pointers and a shared message store.
// The start transfer captures the command and enters S_EXEC; from S_EXEC the result
// registers load with all results and done pulses. No command is accepted while busy;
// the registered store read comes before the update of the slot's pointers and fill.
// Reset clears all head/tail pointers and fill counts and restores the limits (8, 40);
// the message store itself is not cleared. The receiver cannot stall: done lasts one cycle.
module multi_slot_message_fifo
	import msmf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command
	input  logic                  start,
	output logic                  busy,
	input  logic                  opcode,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [LEN_W-1:0]      write_length,
	input  logic [CAP_W-1:0]      read_capacity,
	input  logic [DATA_W-1:0]     write_data,
	// result
	output logic                  done,
	output logic [2:0]            status,
	output logic [LEN_W-1:0]      message_length,
	output logic [DATA_W-1:0]     read_data,
	output logic [FILL_W-1:0]     slot_fill
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// limits
	logic [LEN_W-1:0]  max_msg_q;
	logic [FILL_W-1:0] max_slot_q;

	// per-slot queue state, small enough for flops
	logic [QPTR_W-1:0] head_q [SLOTS];
	logic [QPTR_W-1:0] tail_q [SLOTS];
	logic [FILL_W-1:0] fill_q [SLOTS];

	// command held through the execute cycle
	logic              op_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [LEN_W-1:0]  wlen_s1;
	logic [CAP_W-1:0]  cap_s1;
	logic [DATA_W-1:0] wdata_s1;

	// result registers
	logic              done_q;
	status_t           status_q;
	logic [LEN_W-1:0]  mlen_q;
	logic [DATA_W-1:0] rdata_q;
	logic [FILL_W-1:0] fill_out_q;

	logic   accept;
	logic   exec;
	entry_t head_entry;
	entry_t wr_entry;

	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;
	assign exec   = (state_q == S_EXEC);

	// ---- configuration: values above the built-in sizes saturate ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_q  <= LEN_W'(MESSAGE_BYTES);
			max_slot_q <= FILL_W'(SLOT_BYTES);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MAX_MSG: begin
					max_msg_q <= (cfg_data[LEN_W-1:0] > LEN_W'(MESSAGE_BYTES)) ?
					             LEN_W'(MESSAGE_BYTES) : cfg_data[LEN_W-1:0];
				end
				CFG_MAX_SLOT: begin
					max_slot_q <= (cfg_data > FILL_W'(SLOT_BYTES)) ?
					              FILL_W'(SLOT_BYTES) : cfg_data;
				end
				default: ;
			endcase
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture the command on the start transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode;
			slot_s1  <= slot;
			wlen_s1  <= write_length;
			cap_s1   <= read_capacity;
			wdata_s1 <= write_data;
		end
	end

	// ---- message store; head entry is fetched during the start transfer ----
	logic wr_en;

	msmf_store u_store (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  ({slot, head_q[slot]}),
		.rd_entry (head_entry),
		.wr_en    (wr_en),
		.wr_addr  ({slot_s1, tail_q[slot_s1]}),
		.wr_entry (wr_entry)
	);

	// ---- execute: decide and update the addressed slot ----
	logic [QPTR_W-1:0] cur_head;
	logic [QPTR_W-1:0] cur_tail;
	logic [FILL_W-1:0] cur_fill;
	logic [FILL_W:0]   fill_sum;
	logic              q_full;
	logic              q_empty;
	logic              wr_ok;
	logic              rd_ok;
	status_t           status_d;
	logic [LEN_W-1:0]  mlen_d;
	logic [DATA_W-1:0] rdata_d;
	logic [FILL_W-1:0] fill_d;

	always_comb begin
		cur_head = head_q[slot_s1];
		cur_tail = tail_q[slot_s1];
		cur_fill = fill_q[slot_s1];
		fill_sum = {1'b0, cur_fill} + (FILL_W+1)'(wlen_s1);
		q_full   = (cur_tail + QPTR_W'(1)) == cur_head;  // one entry kept free
		q_empty  = (cur_fill == '0) || (cur_head == cur_tail);

		wr_ok    = 1'b0;
		rd_ok    = 1'b0;
		status_d = STAT_OK;
		mlen_d   = '0;
		rdata_d  = '0;
		fill_d   = cur_fill;

		if (op_s1 == OP_WRITE) begin
			if (wlen_s1 > max_msg_q) begin
				status_d = STAT_TOO_LONG;
			end else if (wlen_s1 == '0) begin
				status_d = STAT_OK;  // empty message: reported ok, nothing stored
			end else if (fill_sum >= {1'b0, max_slot_q} || q_full) begin
				status_d = STAT_NO_ROOM;
			end else begin
				wr_ok  = 1'b1;
				mlen_d = wlen_s1;
				fill_d = fill_sum[FILL_W-1:0];
			end
		end else begin
			if (q_empty) begin
				status_d = STAT_EMPTY;
			end else if (CAP_W'(head_entry.len) > cap_s1) begin
				status_d = STAT_SMALL_BUF;
			end else begin
				rd_ok   = 1'b1;
				mlen_d  = head_entry.len;
				rdata_d = head_entry.data;
				fill_d  = (cur_fill >= FILL_W'(head_entry.len)) ?
				          cur_fill - FILL_W'(head_entry.len) : '0;
			end
		end
	end

	assign wr_en         = exec && wr_ok;
	assign wr_entry.len  = wlen_s1;
	assign wr_entry.data = wdata_s1 & byte_mask(wlen_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (exec) begin
			fill_q[slot_s1] <= fill_d;
			if (wr_ok) tail_q[slot_s1] <= cur_tail + QPTR_W'(1);
			if (rd_ok) head_q[slot_s1] <= cur_head + QPTR_W'(1);
		end
	end

	// ---- result: registered, one-cycle strobe ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= exec;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= status_d;
			mlen_q     <= mlen_d;
			rdata_q    <= rdata_d;
			fill_out_q <= fill_d;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign message_length = mlen_q;
	assign read_data      = rdata_q;
	assign slot_fill      = fill_out_q;

endmodule

// ----- src/msmf_store.sv -----
// Message store: one-port-write, one-port-read synchronous RAM with registered read.
module msmf_store
	import msmf_pkg::*;
(
	input  logic                clk,
	input  logic                rd_en,
	input  logic [STORE_AW-1:0] rd_addr,
	output entry_t              rd_entry,
	input  logic                wr_en,
	input  logic [STORE_AW-1:0] wr_addr,
	input  entry_t              wr_entry
);

	entry_t mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule

// ----- tb/mailbox_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard class for the multi-slot message FIFO: slot predictor and reply checking.
package mailbox_scoreboard_pkg;
	import msmf_pkg::*;

	typedef struct packed {
		status_t           code;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] data;
		logic [FILL_W-1:0] fill;
	} mailbox_reply_t;

	class mailbox_scoreboard;
		logic [LEN_W-1:0]  entry_len  [STORE_DEPTH];
		logic [DATA_W-1:0] entry_data [STORE_DEPTH];
		int head_ptr   [SLOTS];
		int tail_ptr   [SLOTS];
		int fill_bytes [SLOTS];
		int msg_limit;
		int slot_limit;
		mailbox_reply_t expected_replies[$];
		int mismatches;
		int replies_checked;
		int status_seen[5];

		function new();
			for (int s = 0; s < SLOTS; s++) begin
				head_ptr[s]   = 0;
				tail_ptr[s]   = 0;
				fill_bytes[s] = 0;
			end
			msg_limit       = MESSAGE_BYTES;
			slot_limit      = SLOT_BYTES;
			mismatches      = 0;
			replies_checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			int v;
			if (idx == CFG_MAX_MSG) begin
				v = int'(value[LEN_W-1:0]);
				msg_limit = (v > MESSAGE_BYTES) ? MESSAGE_BYTES : v;
			end else if (idx == CFG_MAX_SLOT) begin
				v = int'(value);
				slot_limit = (v > SLOT_BYTES) ? SLOT_BYTES : v;
			end
		endfunction

		// predict the reply of one accepted command and queue it
		function void note_command(logic op, logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] wlen,
				logic [CAP_W-1:0] cap, logic [DATA_W-1:0] wdata);
			mailbox_reply_t r;
			int s;
			int e;
			int hl;
			logic [DATA_W-1:0] kept;
			r      = '0;
			r.code = STAT_OK;
			s      = int'(slot);
			if (s >= SLOTS) begin
				r.code = (op == OP_WRITE) ? STAT_NO_ROOM : STAT_EMPTY;
			end else if (op == OP_WRITE) begin
				if (int'(wlen) > msg_limit) begin
					r.code = STAT_TOO_LONG;
				end else if (wlen == 0) begin
					r.code = STAT_OK;
				end else if (fill_bytes[s] + int'(wlen) >= slot_limit ||
						(tail_ptr[s] + 1) % QUEUE_DEPTH == head_ptr[s]) begin
					r.code = STAT_NO_ROOM;
				end else begin
					kept = '0;
					for (int b = 0; b < DATA_W / 8; b++) begin
						if (b < int'(wlen)) kept[b*8 +: 8] = wdata[b*8 +: 8];
					end
					e = s * QUEUE_DEPTH + tail_ptr[s];
					entry_len[e]  = wlen;
					entry_data[e] = kept;
					tail_ptr[s]   = (tail_ptr[s] + 1) % QUEUE_DEPTH;
					fill_bytes[s] += int'(wlen);
					r.length = wlen;
				end
				r.fill = FILL_W'(fill_bytes[s]);
			end else begin
				if (fill_bytes[s] == 0 || head_ptr[s] == tail_ptr[s]) begin
					r.code = STAT_EMPTY;
				end else begin
					e  = s * QUEUE_DEPTH + head_ptr[s];
					hl = int'(entry_len[e]);
					if (hl > int'(cap)) begin
						r.code = STAT_SMALL_BUF;
					end else begin
						r.data        = entry_data[e];
						r.length      = entry_len[e];
						head_ptr[s]   = (head_ptr[s] + 1) % QUEUE_DEPTH;
						fill_bytes[s] = (fill_bytes[s] >= hl) ? fill_bytes[s] - hl : 0;
					end
				end
				r.fill = FILL_W'(fill_bytes[s]);
			end
			status_seen[int'(r.code)]++;
			expected_replies.push_back(r);
		endfunction

		function void check_reply(logic [2:0] code, logic [LEN_W-1:0] length,
				logic [DATA_W-1:0] data, logic [FILL_W-1:0] fill);
			mailbox_reply_t want;
			replies_checked++;
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: reply with none outstanding: status %0d len %0d data %h fill %0d",
						$time, code, length, data, fill);
			end else begin
				want = expected_replies.pop_front();
				if (code !== want.code || length !== want.length || data !== want.data ||
						fill !== want.fill) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: reply %0d wrong", $time, replies_checked);
						$display("  expected status %0d len %0d data %h fill %0d",
							want.code, want.length, want.data, want.fill);
						$display("  actual   status %0d len %0d data %h fill %0d",
							code, length, data, fill);
					end
				end
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function int failures();
			return mismatches + expected_replies.size();
		endfunction
	endclass

endpackage

// ----- tb/tb_multi_slot_message_fifo.sv -----
`timescale 1ns / 100ps
// Testbench top for the multi-slot message FIFO: directed and random commands, scoreboard check.
module tb_multi_slot_message_fifo;
	import msmf_pkg::*;
	import mailbox_scoreboard_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	logic                  busy;
	logic                  opcode;
	logic [SLOT_W-1:0]     slot;
	logic [LEN_W-1:0]      write_length;
	logic [CAP_W-1:0]      read_capacity;
	logic [DATA_W-1:0]     write_data;
	logic                  done;
	logic [2:0]            status;
	logic [LEN_W-1:0]      message_length;
	logic [DATA_W-1:0]     read_data;
	logic [FILL_W-1:0]     slot_fill;

	mailbox_scoreboard board;
	int writes_sent;
	int reads_sent;
	int settings_used;

	multi_slot_message_fifo dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.slot           (slot),
		.write_length   (write_length),
		.read_capacity  (read_capacity),
		.write_data     (write_data),
		.done           (done),
		.status         (status),
		.message_length (message_length),
		.read_data      (read_data),
		.slot_fill      (slot_fill)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: done lasts one cycle and cannot be held off, so every
	// strobe seen at a rising edge is a completed transfer.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_reply(status, message_length, read_data, slot_fill);
	end

	// One command transfer. Inputs move on the falling edge; the transfer
	// happens on the first rising edge with busy low. start is left high so
	// that a following command goes out back to back.
	task automatic send_command(logic op, logic [SLOT_W-1:0] s, logic [LEN_W-1:0] wlen,
			logic [CAP_W-1:0] cap, logic [DATA_W-1:0] wdata);
		@(negedge clk);
		start         = 1'b1;
		opcode        = op;
		slot          = s;
		write_length  = wlen;
		read_capacity = cap;
		write_data    = wdata;
		do @(posedge clk); while (busy);
		board.note_command(op, s, wlen, cap, wdata);
		if (op == OP_WRITE) writes_sent++;
		else reads_sent++;
	endtask

	// Sender gap; the command fields carry junk that the block must ignore.
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start         = 1'b0;
			opcode        = 1'($urandom);
			slot          = SLOT_W'($urandom);
			write_length  = LEN_W'($urandom);
			read_capacity = CAP_W'($urandom);
			write_data    = {$urandom, $urandom};
		end
	endtask

	// Hold the sender until every outstanding reply has arrived, then let
	// the block settle before anything else touches it.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Register write while idle; only the low 4 bits matter for the message limit.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_write = 1'b0;
		cfg_data  = '0;
		board.note_register(idx, value);
	endtask

	// One random phase under a given pair of limits. Most writes respect the
	// message limit and most reads offer a full buffer, so the slots really
	// fill and drain; the rest take lengths up to 15 and buffers up to 9.
	task automatic run_phase(logic [CFG_DATA_W-1:0] msg_cfg, logic [CFG_DATA_W-1:0] slot_cfg,
			int write_pct, int count, bit idle_on);
		int msg_eff;
		logic op;
		logic [LEN_W-1:0] wlen;
		logic [CAP_W-1:0] cap;
		settle();
		write_register(CFG_MAX_MSG, msg_cfg);
		write_register(CFG_MAX_SLOT, slot_cfg);
		settings_used++;
		msg_eff = int'(msg_cfg[LEN_W-1:0]);
		if (msg_eff > MESSAGE_BYTES) msg_eff = MESSAGE_BYTES;
		for (int n = 0; n < count; n++) begin
			// idle in bursts, with every third stretch of 16 commands left dense
			if (idle_on && ((n / 16) % 3 != 2) && $urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 9));
			op = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_READ;
			if ($urandom_range(0, 9) < 8)
				wlen = LEN_W'($urandom_range(0, msg_eff));
			else
				wlen = LEN_W'($urandom_range(0, 15));
			if ($urandom_range(0, 9) < 6)
				cap = CAP_W'($urandom_range(8, 255));
			else
				cap = CAP_W'($urandom_range(0, 9));
			send_command(op, SLOT_W'($urandom_range(0, SLOTS - 1)), wlen, cap,
				{$urandom, $urandom});
		end
	endtask

	initial begin
		board         = new();
		writes_sent   = 0;
		reads_sent    = 0;
		settings_used = 1;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		start         = 1'b0;
		opcode        = OP_WRITE;
		slot          = '0;
		write_length  = '0;
		read_capacity = '0;
		write_data    = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset limits (8 bytes, 40 per slot).
		send_command(OP_READ,  2'd0, 4'd0,  8'd255, '0);           // empty slot
		send_command(OP_WRITE, 2'd0, 4'd8,  8'd0,   '1);           // full-size message
		send_command(OP_WRITE, 2'd0, 4'd0,  8'd0,   '1);           // zero length: ok, nothing stored
		send_command(OP_WRITE, 2'd0, 4'd9,  8'd0,   '1);           // just over the limit
		send_command(OP_WRITE, 2'd0, 4'd15, 8'd0,   '1);           // largest length code
		send_command(OP_WRITE, 2'd1, 4'd3,  8'd0,   '1);           // upper bytes must be dropped
		send_command(OP_READ,  2'd1, 4'd0,  8'd2,   '0);           // buffer one byte short
		send_command(OP_READ,  2'd1, 4'd15, 8'd3,   '1);           // exact fit, junk in write fields
		send_command(OP_READ,  2'd0, 4'd15, 8'd255, '1);
		send_command(OP_WRITE, 2'd2, 4'd8,  8'd0,   64'h0123_4567_89ab_cdef);
		send_command(OP_WRITE, 2'd2, 4'd8,  8'd0,   64'ha5a5_a5a5_a5a5_a5a5);
		send_command(OP_WRITE, 2'd2, 4'd8,  8'd0,   64'h5a5a_5a5a_5a5a_5a5a);
		send_command(OP_WRITE, 2'd2, 4'd8,  8'd0,   '0);
		send_command(OP_WRITE, 2'd2, 4'd8,  8'd0,   '1);           // would reach the slot limit
		send_command(OP_WRITE, 2'd2, 4'd7,  8'd0,   '1);           // lands one below it
		send_command(OP_WRITE, 2'd2, 4'd1,  8'd0,   '1);           // no room for even one byte
		send_command(OP_WRITE, 2'd2, 4'd0,  8'd0,   '1);           // zero length on a full slot
		send_command(OP_WRITE, 2'd3, 4'd1,  8'd0,   64'hffff_ffff_ffff_ff00);
		send_command(OP_READ,  2'd3, 4'd0,  8'd0,   '0);           // zero-size buffer
		send_command(OP_READ,  2'd3, 4'd0,  8'd1,   '0);

		// Random phases. Slot 2 holds 39 bytes as they begin, and the second
		// phase lowers both limits to zero, so that case is met early. Message-limit values
		// carry junk in bits 5:4 and out-of-range values to be saturated.
		run_phase(6'd8,  6'd40, 60, 130, 1'b1);
		run_phase(6'h10, 6'd0,  50,  60, 1'b1);
		run_phase(6'h3f, 6'd63, 70, 130, 1'b1);
		run_phase(6'h21, 6'd1,  50,  60, 1'b1);
		run_phase(6'd3,  6'd12, 55, 110, 1'b1);
		run_phase(6'd8,  6'd20, 65, 110, 1'b1);
		run_phase(6'h14, 6'd40, 40, 100, 1'b1);
		run_phase(6'd8,  6'd40, 55, 230, 1'b0);                     // closing stretch, no gaps
		settle();

		$display("Covered %0d commands (%0d writes, %0d reads) under %0d limit settings.",
			writes_sent + reads_sent, writes_sent, reads_sent, settings_used);
		$display("Replies by status: ok %0d, too long %0d, no room %0d, empty %0d, small %0d.",
			board.status_seen[STAT_OK], board.status_seen[STAT_TOO_LONG],
			board.status_seen[STAT_NO_ROOM], board.status_seen[STAT_EMPTY],
			board.status_seen[STAT_SMALL_BUF]);
		if (board.failures() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/msmf_pkg.sv
src/msmf_store.sv
src/multi_slot_message_fifo.sv
tb/mailbox_scoreboard_pkg.sv
tb/tb_multi_slot_message_fifo.sv
